// ----- hw/rtl/aat_pkg.sv -----
`timescale 1ns / 1ps

package aat_pkg;

    localparam int FIELD_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_HALF        = 32;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int NUM_AXES        = 3;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2_COLS23 = 3'd5;

    typedef struct packed {
        logic prod;
        logic sel;
        logic sum;
        logic sat;
    } aat_stage_en_t;

endpackage

// ----- hw/rtl/aat_row.sv -----
`timescale 1ns / 1ps

module aat_row
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  aat_stage_en_t                 en,
    input  logic signed [COORD_WIDTH-1:0] coef  [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] trans,
    input  logic signed [COORD_WIDTH-1:0] lo    [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] hi    [NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] res_lo,
    output logic signed [COORD_WIDTH-1:0] res_hi
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-COORD_WIDTH+1){1'b0}},
                                                {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-COORD_WIDTH+1){1'b1}},
                                                {(COORD_WIDTH-1){1'b0}}};

    logic signed [PW-1:0] plo_reg  [NUM_AXES];
    logic signed [PW-1:0] phi_reg  [NUM_AXES];
    logic signed [PW-1:0] tmin_reg [NUM_AXES];
    logic signed [PW-1:0] tmax_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] trans_d_reg;
    logic signed [SW-1:0] smin_reg;
    logic signed [SW-1:0] smax_reg;
    logic signed [COORD_WIDTH-1:0] res_lo_reg;
    logic signed [COORD_WIDTH-1:0] res_hi_reg;

    logic signed [SW-1:0] smin_next;
    logic signed [SW-1:0] smax_next;
    logic signed [COORD_WIDTH-1:0] res_lo_next;
    logic signed [COORD_WIDTH-1:0] res_hi_next;

    // products, floor shift is pure wiring after the multiply
    always_ff @(posedge aclk) begin
        if (en.prod) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                plo_reg[a] <= (PW'(coef[a]) * PW'(lo[a])) >>> FRAC_BITS;
                phi_reg[a] <= (PW'(coef[a]) * PW'(hi[a])) >>> FRAC_BITS;
            end
        end
    end

    // each term depends on one coordinate only, so pick its extremes
    always_ff @(posedge aclk) begin
        if (en.sel) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                if (plo_reg[a] < phi_reg[a]) begin
                    tmin_reg[a] <= plo_reg[a];
                    tmax_reg[a] <= phi_reg[a];
                end else begin
                    tmin_reg[a] <= phi_reg[a];
                    tmax_reg[a] <= plo_reg[a];
                end
            end
            trans_d_reg <= trans;
        end
    end

    always_comb begin
        smin_next = SW'(tmin_reg[0]) + SW'(tmin_reg[1]) + SW'(tmin_reg[2])
                  + SW'(trans_d_reg);
        smax_next = SW'(tmax_reg[0]) + SW'(tmax_reg[1]) + SW'(tmax_reg[2])
                  + SW'(trans_d_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
    end

    // saturation is monotonic, so it commutes with min and max
    always_comb begin
        priority if (smin_reg > SAT_MAX) begin
            res_lo_next = SAT_MAX[COORD_WIDTH-1:0];
        end else if (smin_reg < SAT_MIN) begin
            res_lo_next = SAT_MIN[COORD_WIDTH-1:0];
        end else begin
            res_lo_next = smin_reg[COORD_WIDTH-1:0];
        end
        priority if (smax_reg > SAT_MAX) begin
            res_hi_next = SAT_MAX[COORD_WIDTH-1:0];
        end else if (smax_reg < SAT_MIN) begin
            res_hi_next = SAT_MIN[COORD_WIDTH-1:0];
        end else begin
            res_hi_next = smax_reg[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sat) begin
            res_lo_reg <= res_lo_next;
            res_hi_reg <= res_hi_next;
        end
    end

    assign res_lo = res_lo_reg;
    assign res_hi = res_hi_reg;

endmodule

// ----- hw/rtl/aabb_affine_transform_core.sv -----
`timescale 1ns / 1ps

// Maps an axis-aligned box through the upper three rows of a 4x4 affine matrix
// and returns the box that bounds the eight mapped corners, all in signed fixed
// point with FRAC_BITS fraction bits held in COORD_WIDTH bits. The block takes
// one box every clock cycle while the m_ side does not hold back the output.
// Each accepted box passes through five registers on its way to the m_ side:
// input register, 18 parallel multipliers (one per coefficient and corner
// coordinate), min/max select per term, the four-term sum, then saturation into
// the output register. Each stage holds under back-pressure without losing or
// repeating a box. The matrix is loaded through the cfg port (index 0..5, low
// half = first column, high half = second column or translation) and must only
// be changed while no box is in flight.

module aabb_affine_transform_core
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]         cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]        cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [FIELD_WIDTH-1:0]    s_lo_x,
    input  logic signed [FIELD_WIDTH-1:0]    s_lo_y,
    input  logic signed [FIELD_WIDTH-1:0]    s_lo_z,
    input  logic signed [FIELD_WIDTH-1:0]    s_hi_x,
    input  logic signed [FIELD_WIDTH-1:0]    s_hi_y,
    input  logic signed [FIELD_WIDTH-1:0]    s_hi_z,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [FIELD_WIDTH-1:0]    m_out_lo_x,
    output logic signed [FIELD_WIDTH-1:0]    m_out_lo_y,
    output logic signed [FIELD_WIDTH-1:0]    m_out_lo_z,
    output logic signed [FIELD_WIDTH-1:0]    m_out_hi_x,
    output logic signed [FIELD_WIDTH-1:0]    m_out_hi_y,
    output logic signed [FIELD_WIDTH-1:0]    m_out_hi_z
);

    localparam int NUM_STAGES = 5;
    localparam logic [CFG_DATA_WIDTH-1:0] ONE = CFG_DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [COORD_WIDTH-1:0] ONE_W = ONE[COORD_WIDTH-1:0];

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;
    aat_stage_en_t         en;

    logic signed [COORD_WIDTH-1:0] coef_reg  [NUM_AXES][NUM_AXES];
    logic signed [COORD_WIDTH-1:0] trans_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] lo_reg    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi_reg    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] row_lo    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] row_hi    [NUM_AXES];

    logic signed [COORD_WIDTH-1:0] cfg_lo_half;
    logic signed [COORD_WIDTH-1:0] cfg_hi_half;

    assign cfg_ready   = 1'b1;
    assign cfg_lo_half = cfg_data[COORD_WIDTH-1:0];
    assign cfg_hi_half = cfg_data[CFG_HALF+COORD_WIDTH-1:CFG_HALF];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                for (int c = 0; c < NUM_AXES; c++) begin
                    coef_reg[r][c] <= (r == c) ? ONE_W : '0;
                end
                trans_reg[r] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROW0_COLS01: begin
                    coef_reg[0][0] <= cfg_lo_half;
                    coef_reg[0][1] <= cfg_hi_half;
                end
                REG_ROW0_COLS23: begin
                    coef_reg[0][2] <= cfg_lo_half;
                    trans_reg[0]   <= cfg_hi_half;
                end
                REG_ROW1_COLS01: begin
                    coef_reg[1][0] <= cfg_lo_half;
                    coef_reg[1][1] <= cfg_hi_half;
                end
                REG_ROW1_COLS23: begin
                    coef_reg[1][2] <= cfg_lo_half;
                    trans_reg[1]   <= cfg_hi_half;
                end
                REG_ROW2_COLS01: begin
                    coef_reg[2][0] <= cfg_lo_half;
                    coef_reg[2][1] <= cfg_hi_half;
                end
                REG_ROW2_COLS23: begin
                    coef_reg[2][2] <= cfg_lo_half;
                    trans_reg[2]   <= cfg_hi_half;
                end
                default: begin
                end
            endcase
        end
    end

    // a stage may load when it is empty or its word moves on
    always_comb begin
        rdy[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next = v_reg;
        if (rdy[0]) begin
            v_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign en.prod = rdy[1];
    assign en.sel  = rdy[2];
    assign en.sum  = rdy[3];
    assign en.sat  = rdy[4];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            lo_reg[0] <= s_lo_x[COORD_WIDTH-1:0];
            lo_reg[1] <= s_lo_y[COORD_WIDTH-1:0];
            lo_reg[2] <= s_lo_z[COORD_WIDTH-1:0];
            hi_reg[0] <= s_hi_x[COORD_WIDTH-1:0];
            hi_reg[1] <= s_hi_y[COORD_WIDTH-1:0];
            hi_reg[2] <= s_hi_z[COORD_WIDTH-1:0];
        end
    end

    for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
        aat_row #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_row (
            .aclk   (aclk),
            .en     (en),
            .coef   (coef_reg[r]),
            .trans  (trans_reg[r]),
            .lo     (lo_reg),
            .hi     (hi_reg),
            .res_lo (row_lo[r]),
            .res_hi (row_hi[r])
        );
    end

    assign s_ready    = rdy[0];
    assign m_valid    = v_reg[NUM_STAGES-1];
    assign m_out_lo_x = FIELD_WIDTH'(row_lo[0]);
    assign m_out_lo_y = FIELD_WIDTH'(row_lo[1]);
    assign m_out_lo_z = FIELD_WIDTH'(row_lo[2]);
    assign m_out_hi_x = FIELD_WIDTH'(row_hi[0]);
    assign m_out_hi_y = FIELD_WIDTH'(row_hi[1]);
    assign m_out_hi_z = FIELD_WIDTH'(row_hi[2]);

endmodule

// ----- tb/sv/aabb_bound_checker.sv -----
`timescale 1ns / 1ps

module aabb_bound_checker
    import aat_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [FIELD_WIDTH-1:0] s_lo_x,
    input  logic signed [FIELD_WIDTH-1:0] s_lo_y,
    input  logic signed [FIELD_WIDTH-1:0] s_lo_z,
    input  logic signed [FIELD_WIDTH-1:0] s_hi_x,
    input  logic signed [FIELD_WIDTH-1:0] s_hi_y,
    input  logic signed [FIELD_WIDTH-1:0] s_hi_z,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [FIELD_WIDTH-1:0] m_out_lo_x,
    input  logic signed [FIELD_WIDTH-1:0] m_out_lo_y,
    input  logic signed [FIELD_WIDTH-1:0] m_out_lo_z,
    input  logic signed [FIELD_WIDTH-1:0] m_out_hi_x,
    input  logic signed [FIELD_WIDTH-1:0] m_out_hi_y,
    input  logic signed [FIELD_WIDTH-1:0] m_out_hi_z,

    output int                            mismatches,
    output int                            in_flight,
    output int                            results_seen
);

    typedef logic signed [FIELD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
    } box_t;

    localparam logic signed [63:0] SUM_MAX     = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] SUM_MIN     = -64'sh8000_0000;
    localparam coord_t             Q_ONE       = 1 <<< FRAC_BITS_DEF;
    localparam int                 MAX_PRINTED = 40;

    logic [CFG_DATA_WIDTH-1:0] row0_c01, row0_c23;
    logic [CFG_DATA_WIDTH-1:0] row1_c01, row1_c23;
    logic [CFG_DATA_WIDTH-1:0] row2_c01, row2_c23;

    box_t  bounds_due [$];
    string field_names [6];

    initial begin
        mismatches   = 0;
        in_flight    = 0;
        results_seen = 0;
        field_names  = '{"out_lo_x", "out_lo_y", "out_lo_z", "out_hi_x", "out_hi_y", "out_hi_z"};
    end

    task automatic report_mismatch(input string what, input coord_t got_v, input coord_t want_v);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got_v, want_v);
    endtask

    // product truncated toward minus infinity
    function automatic logic signed [63:0] scaled(input coord_t coef, input coord_t v);
        logic signed [63:0] p;
        p = coef * v;
        return p >>> FRAC_BITS_DEF;
    endfunction

    function automatic coord_t map_row(input logic [CFG_DATA_WIDTH-1:0] c01,
                                       input logic [CFG_DATA_WIDTH-1:0] c23,
                                       input coord_t x, input coord_t y, input coord_t z);
        logic signed [63:0] acc;
        coord_t             shift;
        shift = c23[CFG_DATA_WIDTH-1:CFG_HALF];
        acc = scaled(c01[CFG_HALF-1:0], x) + scaled(c01[CFG_DATA_WIDTH-1:CFG_HALF], y)
            + scaled(c23[CFG_HALF-1:0], z) + shift;
        if (acc > SUM_MAX)
            return SUM_MAX[FIELD_WIDTH-1:0];
        if (acc < SUM_MIN)
            return SUM_MIN[FIELD_WIDTH-1:0];
        return acc[FIELD_WIDTH-1:0];
    endfunction

    function automatic box_t bound_of_mapped(input box_t b);
        box_t   r;
        coord_t x, y, z, px, py, pz;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            x  = k[0] ? b.hi_x : b.lo_x;
            y  = k[1] ? b.hi_y : b.lo_y;
            z  = k[2] ? b.hi_z : b.lo_z;
            px = map_row(row0_c01, row0_c23, x, y, z);
            py = map_row(row1_c01, row1_c23, x, y, z);
            pz = map_row(row2_c01, row2_c23, x, y, z);
            if (k == 0 || px < r.lo_x) r.lo_x = px;
            if (k == 0 || py < r.lo_y) r.lo_y = py;
            if (k == 0 || pz < r.lo_z) r.lo_z = pz;
            if (k == 0 || px > r.hi_x) r.hi_x = px;
            if (k == 0 || py > r.hi_y) r.hi_y = py;
            if (k == 0 || pz > r.hi_z) r.hi_z = pz;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        box_t want, got;
        if (!aresetn) begin
            row0_c01 = {32'd0, Q_ONE};
            row0_c23 = '0;
            row1_c01 = {Q_ONE, 32'd0};
            row1_c23 = '0;
            row2_c01 = '0;
            row2_c23 = {32'd0, Q_ONE};
            bounds_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ROW0_COLS01: row0_c01 = cfg_data;
                    REG_ROW0_COLS23: row0_c23 = cfg_data;
                    REG_ROW1_COLS01: row1_c01 = cfg_data;
                    REG_ROW1_COLS23: row1_c23 = cfg_data;
                    REG_ROW2_COLS01: row2_c01 = cfg_data;
                    REG_ROW2_COLS23: row2_c23 = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{m_out_lo_x, m_out_lo_y, m_out_lo_z, m_out_hi_x, m_out_hi_y, m_out_hi_z};
                results_seen++;
                if (bounds_due.size() == 0) begin
                    report_mismatch("word with no box pending", got.lo_x, '0);
                end else begin
                    want = bounds_due.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (got[(5-f)*FIELD_WIDTH +: FIELD_WIDTH] !==
                            want[(5-f)*FIELD_WIDTH +: FIELD_WIDTH])
                            report_mismatch(field_names[f],
                                            got[(5-f)*FIELD_WIDTH +: FIELD_WIDTH],
                                            want[(5-f)*FIELD_WIDTH +: FIELD_WIDTH]);
                end
            end
            if (s_valid && s_ready)
                bounds_due.insert(bounds_due.size(),
                                  bound_of_mapped('{s_lo_x, s_lo_y, s_lo_z,
                                                    s_hi_x, s_hi_y, s_hi_z}));
        end
        in_flight = bounds_due.size();
    end

endmodule

// ----- tb/sv/tb_aabb_affine_transform_core.sv -----
`timescale 1ns / 1ps

module tb_aabb_affine_transform_core;
    import aat_pkg::*;

    typedef logic signed [FIELD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
    } box_t;

    localparam coord_t COORD_MAX   = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN   = 32'sh8000_0000;
    localparam coord_t Q_ONE       = 32'sh0001_0000;
    localparam int     HOLD_CYCLES = 400;
    localparam int     STALL_LIMIT = 5000;
    localparam int     DRAIN_WAIT  = 20;

    // indexes past the last matrix register
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    coord_t                    s_lo_x, s_lo_y, s_lo_z, s_hi_x, s_hi_y, s_hi_z;
    logic                      m_valid;
    logic                      m_ready;
    coord_t                    m_out_lo_x, m_out_lo_y, m_out_lo_z;
    coord_t                    m_out_hi_x, m_out_hi_y, m_out_hi_z;

    int mismatches;
    int in_flight;
    int results_seen;
    int boxes_sent;
    int reg_writes;
    int matrix_settings;
    int quiet_cycles;
    bit idle_on;
    bit hold_req;

    aabb_affine_transform_core u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_lo_x     (s_lo_x),
        .s_lo_y     (s_lo_y),
        .s_lo_z     (s_lo_z),
        .s_hi_x     (s_hi_x),
        .s_hi_y     (s_hi_y),
        .s_hi_z     (s_hi_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_lo_x (m_out_lo_x),
        .m_out_lo_y (m_out_lo_y),
        .m_out_lo_z (m_out_lo_z),
        .m_out_hi_x (m_out_hi_x),
        .m_out_hi_y (m_out_hi_y),
        .m_out_hi_z (m_out_hi_z)
    );

    aabb_bound_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_lo_x       (s_lo_x),
        .s_lo_y       (s_lo_y),
        .s_lo_z       (s_lo_z),
        .s_hi_x       (s_hi_x),
        .s_hi_y       (s_hi_y),
        .s_hi_z       (s_hi_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_lo_x   (m_out_lo_x),
        .m_out_lo_y   (m_out_lo_y),
        .m_out_lo_z   (m_out_lo_z),
        .m_out_hi_x   (m_out_hi_x),
        .m_out_hi_y   (m_out_hi_y),
        .m_out_hi_z   (m_out_hi_z),
        .mismatches   (mismatches),
        .in_flight    (in_flight),
        .results_seen (results_seen)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic box_t mk_box(input coord_t lx, input coord_t ly, input coord_t lz,
                                    input coord_t hx, input coord_t hy, input coord_t hz);
        box_t b;
        b = '{lx, ly, lz, hx, hy, hz};
        return b;
    endfunction

    function automatic coord_t rand_coord(input int span);
        case (span)
            0: return $urandom;
            // about plus or minus 1024.0
            1: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return Q_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        int   kind;
        int   span;
        kind = $urandom_range(0, 99);
        span = (kind < 55) ? 1 : (kind < 80) ? 0 : 2;
        b = mk_box(rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span), rand_coord(span));
        if (kind < 70) begin
            if (b.lo_x > b.hi_x) {b.lo_x, b.hi_x} = {b.hi_x, b.lo_x};
            if (b.lo_y > b.hi_y) {b.lo_y, b.hi_y} = {b.hi_y, b.lo_y};
            if (b.lo_z > b.hi_z) {b.lo_z, b.hi_z} = {b.hi_z, b.lo_z};
        end else if (kind < 76) begin
            b.hi_x = b.lo_x;
            b.hi_y = b.lo_y;
            b.hi_z = b.lo_z;
        end
        return b;
    endfunction

    function automatic coord_t small_coef();
        // about plus or minus 4.0
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    // called at a falling edge, returns at a falling edge with s_valid possibly still high
    task automatic push_box(input box_t b);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_lo_x  <= b.lo_x;
        s_lo_y  <= b.lo_y;
        s_lo_z  <= b.lo_z;
        s_hi_x  <= b.hi_x;
        s_hi_y  <= b.hi_y;
        s_hi_z  <= b.hi_z;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        boxes_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (in_flight != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_matrix(input logic [CFG_DATA_WIDTH-1:0] r0c01, input logic [CFG_DATA_WIDTH-1:0] r0c23,
                               input logic [CFG_DATA_WIDTH-1:0] r1c01, input logic [CFG_DATA_WIDTH-1:0] r1c23,
                               input logic [CFG_DATA_WIDTH-1:0] r2c01, input logic [CFG_DATA_WIDTH-1:0] r2c23);
        write_reg(REG_ROW0_COLS01, r0c01);
        write_reg(REG_ROW0_COLS23, r0c23);
        write_reg(REG_ROW1_COLS01, r1c01);
        write_reg(REG_ROW1_COLS23, r1c23);
        write_reg(REG_ROW2_COLS01, r2c01);
        write_reg(REG_ROW2_COLS23, r2c23);
        matrix_settings++;
    endtask

    task automatic load_random_small();
        load_matrix({small_coef(), small_coef()}, {rand_coord(1), small_coef()},
                    {small_coef(), small_coef()}, {rand_coord(1), small_coef()},
                    {small_coef(), small_coef()}, {rand_coord(1), small_coef()});
    endtask

    task automatic run_boxes(input int n, input bit with_idle);
        idle_on = with_idle;
        repeat (n) push_box(random_box());
        wait_drained();
    endtask

    task automatic push_corner_set();
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        // inverted box
        push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        push_box(mk_box(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                        32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000));
        // odd negative values expose rounding toward minus infinity
        push_box(mk_box(-1, -3, -5, 1, 3, 5));
        push_box(mk_box(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                        32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
    endtask

    // receiver back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d boxes pending",
                     quiet_cycles, in_flight);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_lo_x          = '0;
        s_lo_y          = '0;
        s_lo_z          = '0;
        s_hi_x          = '0;
        s_hi_y          = '0;
        s_hi_z          = '0;
        idle_on         = 1'b0;
        hold_req        = 1'b0;
        quiet_cycles    = 0;
        boxes_sent      = 0;
        reg_writes      = 0;
        matrix_settings = 1;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset matrix is the identity
        push_corner_set();
        wait_drained();

        // mixed signs, fractional scales, translations at both extremes
        load_matrix({-32'sh0002_0000, 32'sh0000_8000}, {-32'sh0003_8000, 32'sh0000_4000},
                    {32'sh0000_8000, -32'sh0001_0000}, {COORD_MAX, 32'sh0002_0000},
                    {32'sh0000_0000, 32'sh0003_0000}, {COORD_MIN, -32'sh0000_8000});
        write_reg(REG_UNMAPPED_LO, {$urandom, $urandom});
        write_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
        push_corner_set();
        push_box(mk_box(32'sh1234_5678, -32'sh0765_4321, COORD_MIN,
                        32'sh1234_5678, -32'sh0765_4321, COORD_MIN));
        wait_drained();
        run_boxes(220, 1'b1);

        // long receiver hold while the sender keeps offering
        load_random_small();
        run_boxes(100, 1'b1);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (60) push_box(random_box());
        run_boxes(150, 1'b1);

        load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        run_boxes(220, 1'b1);

        load_matrix({COORD_MAX, COORD_MAX}, {COORD_MAX, COORD_MAX}, {COORD_MAX, COORD_MAX},
                    {COORD_MAX, COORD_MAX}, {COORD_MAX, COORD_MAX}, {COORD_MAX, COORD_MAX});
        run_boxes(200, 1'b1);

        load_matrix({COORD_MIN, COORD_MIN}, {COORD_MIN, COORD_MIN}, {COORD_MIN, COORD_MIN},
                    {COORD_MIN, COORD_MIN}, {COORD_MIN, COORD_MIN}, {COORD_MIN, COORD_MIN});
        run_boxes(200, 1'b0);

        load_matrix('0, '0, '0, '0, '0, '0);
        run_boxes(150, 1'b1);

        // axes permuted and negated, sender pauses for a full drain midway
        load_matrix({-Q_ONE, 32'sh0}, {rand_coord(1), 32'sh0},
                    {32'sh0, 32'sh0}, {rand_coord(1), -Q_ONE},
                    {32'sh0, -Q_ONE}, {rand_coord(1), 32'sh0});
        run_boxes(115, 1'b1);
        run_boxes(115, 1'b0);

        load_random_small();
        run_boxes(220, 1'b0);

        load_matrix({32'sh0, Q_ONE}, '0, {Q_ONE, 32'sh0}, '0, '0, {32'sh0, Q_ONE});
        write_reg(REG_UNMAPPED_HI, {$urandom, $urandom});
        write_reg(REG_UNMAPPED_LO, {$urandom, $urandom});
        run_boxes(200, 1'b1);

        repeat (DRAIN_WAIT) @(negedge aclk);
        $display("boxes sent %0d, result words checked %0d, mismatches %0d",
                 boxes_sent, results_seen, mismatches);
        $display("matrix settings %0d incl. saturating and zero extremes, %0d register writes",
                 matrix_settings, reg_writes);
        if (mismatches == 0 && in_flight == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
